@@ hdl/sfr_pkg.sv @@
// Shared types and constants for the SBUS frame receiver.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package sfr_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FTR_BYTE = 8'h00;

  localparam int FRAME_LEN = 25;
  localparam int STORE_LEN = 23;
  localparam int DATA_BYTES = STORE_LEN - 1;
  localparam int NUM_CH = 16;
  localparam int CH_W = 11;
  localparam int IDX_W = 4;
  localparam int DATA_W = DATA_BYTES * 8;
  localparam int POS_W = 5;
  localparam int FLAG_W = 4;

  // byte_position codes
  localparam logic [POS_W-1:0] POS_IDLE = '0;
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FOOTER = POS_W'(FRAME_LEN - 1);

  // flag byte bits
  localparam int FLAG_CH17 = 0;
  localparam int FLAG_CH18 = 1;
  localparam int FLAG_LOST = 2;
  localparam int FLAG_FS = 3;

  localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CH - 1);

  // frame queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = 1;
  localparam int QUEUE_CW = 2;

  // one good frame: packed channel data, little-endian, plus flag nibble
  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [DATA_W-1:0] data;
  } frame_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

@@ hdl/sfr_front.sv @@
// Front part: tracks byte position and previous byte, stores frame bytes,
// checks header and footer, and pushes good frames. Uses sfr_pkg.
`default_nettype none

module sfr_front import sfr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  queue_status_t      q_status,
  output logic               push,
  output frame_t             push_frame
);

  logic [POS_W-1:0] byte_position;
  logic [7:0]       prior_byte;
  logic [7:0]       frame_store [STORE_LEN];
  logic             accept;
  logic             at_footer;

  assign at_footer = (byte_position >= POS_FOOTER);
  // only the footer byte may need a queue slot
  assign in_ready = !(at_footer && q_status.full);
  assign accept = in_valid && in_ready;
  assign push = accept && at_footer && (rx_byte == FTR_BYTE);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
      prior_byte <= FTR_BYTE;
    end else if (accept) begin
      prior_byte <= rx_byte;
      if (byte_position == POS_IDLE) begin
        if ((rx_byte == HDR_BYTE) && (prior_byte == FTR_BYTE)) begin
          byte_position <= POS_FIRST;
        end
      end else if (!at_footer) begin
        byte_position <= byte_position + POS_W'(1);
      end else begin
        byte_position <= POS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (byte_position != POS_IDLE) && !at_footer) begin
      frame_store[byte_position - POS_W'(1)] <= rx_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      push_frame.data[8*i +: 8] = frame_store[i];
    end
    push_frame.flags = frame_store[STORE_LEN-1][FLAG_W-1:0];
  end

endmodule

`default_nettype wire

@@ hdl/sfr_queue.sv @@
// Two-entry frame queue between the front and back parts.
// Uses sfr_pkg for frame_t and the queue sizes.
`default_nettype none

module sfr_queue import sfr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  frame_t        push_frame,
  input  wire logic     pop,
  output frame_t        pop_frame,
  output queue_status_t status
);

  frame_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign status.full = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_frame = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sfr_back.sv @@
// Back part: takes one frame from the queue and shifts out its 16 channel
// words, 11 bits each, with the flag bits. Uses sfr_pkg.
`default_nettype none

module sfr_back import sfr_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  queue_status_t      q_status,
  input  frame_t             pop_frame,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [IDX_W-1:0]   channel_index,
  output logic [CH_W-1:0]    channel_value,
  output logic               digital_ch17,
  output logic               digital_ch18,
  output logic               frame_lost,
  output logic               fail_safe,
  output logic               last
);

  logic              active;
  logic [IDX_W-1:0]  ch_count;
  logic [DATA_W-1:0] shifter;
  logic [FLAG_W-1:0] flags;
  logic              out_take;

  assign out_take = out_valid && out_ready;
  assign last = (ch_count == LAST_CH);
  assign pop = !q_status.empty && (!active || (out_take && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      ch_count <= '0;
    end else if (pop) begin
      active <= 1'b1;
      ch_count <= '0;
    end else if (out_take) begin
      ch_count <= ch_count + IDX_W'(1);
      if (last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shifter <= pop_frame.data;
      flags <= pop_frame.flags;
    end else if (out_take) begin
      shifter <= {CH_W'(0), shifter[DATA_W-1:CH_W]};
    end
  end

  assign out_valid = active;
  assign channel_index = ch_count;
  assign channel_value = shifter[CH_W-1:0];
  assign digital_ch17 = flags[FLAG_CH17];
  assign digital_ch18 = flags[FLAG_CH18];
  assign frame_lost = flags[FLAG_LOST];
  assign fail_safe = flags[FLAG_FS];

endmodule

`default_nettype wire

@@ hdl/sbus_frame_receiver_core.sv @@
// SBUS frame receiver top level: front part, frame queue and back part.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
//   channel   | direction | handshake            | word
//   ----------+-----------+----------------------+------------------------------
//   input     | in        | in_valid / in_ready  | rx_byte, one received byte
//   output    | out       | out_valid / out_ready| one channel: index, value,
//             |           |                      | four flag bits, last
//
// One byte is taken per cycle; in_ready drops only on a footer byte while
// both queue slots hold frames not yet sent.
// A good frame's first word is offered once its footer has pushed it into
// a queue slot and the back part's shifter has loaded it; the 16 words go
// out one word per cycle while out_ready stays high, shifting 11 bits each.
// The queue holds two finished frames, so input keeps flowing while output
// is stalled. Reset (rst, synchronous) returns to waiting for a header with
// the previous byte taken as the footer value and empties the queue.
`default_nettype none

module sbus_frame_receiver_core import sfr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       channel_index,
  output logic [CH_W-1:0]        channel_value,
  output logic                   digital_ch17,
  output logic                   digital_ch18,
  output logic                   frame_lost,
  output logic                   fail_safe,
  output logic                   last
);

  queue_status_t q_status;
  frame_t        push_frame;
  frame_t        pop_frame;
  logic          push;
  logic          pop;

  // header/footer framing and byte store
  sfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_status   (q_status),
    .push       (push),
    .push_frame (push_frame)
  );

  // decouples framing from the channel serializer
  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (q_status)
  );

  // 16 channel words per frame
  sfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .pop_frame     (pop_frame),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .digital_ch17  (digital_ch17),
    .digital_ch18  (digital_ch18),
    .frame_lost    (frame_lost),
    .fail_safe     (fail_safe),
    .last          (last)
  );

endmodule

`default_nettype wire

@@ hdl/sfr_checker.sv @@
// Port-level checks for sbus_frame_receiver_core, with the bind that attaches
// them. Uses sfr_pkg for field widths.
`default_nettype none

module sfr_checker import sfr_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic [7:0]       rx_byte,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [IDX_W-1:0] channel_index,
  input wire logic [CH_W-1:0]  channel_value,
  input wire logic             digital_ch17,
  input wire logic             digital_ch18,
  input wire logic             frame_lost,
  input wire logic             fail_safe,
  input wire logic             last
);

  // a waiting input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> (in_valid && $stable(rx_byte)))
    else $error("input word changed while waiting");

  // words of a frame follow each other with rising index
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && (channel_index == $past(channel_index) + IDX_W'(1))))
    else $error("channel index did not advance within a frame");

  // last marks channel 15 and nothing else
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (channel_index == LAST_CH)))
    else $error("last does not match channel 15");

  // flag bits are constant over one frame
  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      ($stable(digital_ch17) && $stable(digital_ch18) &&
       $stable(frame_lost) && $stable(fail_safe)))
    else $error("flag bits changed inside a frame");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(channel_index) && $stable(channel_value)))
    else $error("output word changed while stalled");

endmodule

bind sbus_frame_receiver_core sfr_checker u_sfr_checker (.*);

`default_nettype wire

@@ tb/sv/sbus_frame_receiver_core_test.sv @@
// Self-checking testbench for sbus_frame_receiver_core: drives received bytes,
// predicts the 16 channel words of every good frame and checks each output word.
// Depends on sfr_pkg and the sbus_frame_receiver_core RTL.
`timescale 1ns / 1ps

module sbus_frame_receiver_core_test;
  import sfr_pkg::*;

  // No-progress limit: the longest legal quiet stretch is one long gap on
  // either side or the final settle, far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_PRINTS = 40;
  // Framed bytes (bytes the decoder does not ignore) at which stimulus stops.
  localparam int MID_TARGET = 150;
  localparam int END_TARGET = 330;

  // One expected channel word.
  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  value;
    logic             ch17;
    logic             ch18;
    logic             lost;
    logic             fs;
    logic             last_ch;
  } chan_word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [7:0]        rx_byte = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  channel_index;
  logic [CH_W-1:0]   channel_value;
  logic              digital_ch17;
  logic              digital_ch18;
  logic              frame_lost;
  logic              fail_safe;
  logic              last;

  // Decoder state mirrored by the predictor.
  logic [POS_W-1:0]  rx_pos = POS_IDLE;
  logic [7:0]        rx_prev = FTR_BYTE;
  logic [7:0]        frame_bytes [STORE_LEN];

  chan_word_t        expected_words [$];
  int                framed_bytes = 0;
  int                errors = 0;
  int                idle_cycles = 0;

  // Idle shaping: calm stretches turn all gaps off for a while.
  logic              calm = 1'b0;
  int                calm_left = 0;
  int                stall_left = 0;

  always #2 clk = ~clk;

  sbus_frame_receiver_core DUT (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .digital_ch17  (digital_ch17),
    .digital_ch18  (digital_ch18),
    .frame_lost    (frame_lost),
    .fail_safe     (fail_safe),
    .last          (last)
  );

  // Gap length: mostly none or short, now and then long; none while calm.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
      calm_left <= $urandom_range(50, 300);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Receiver back-pressure: out_ready drops for a random stall now and then.
  always @(negedge clk) begin : out_ready_drive
    int g;
    g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (g > 0) begin
      out_ready <= 1'b0;
      stall_left <= g - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Decoder prediction for one accepted byte. A good footer queues the 16
  // channel words: channel k is bits 11k..11k+10 of the 22 data bytes taken
  // little-endian, and every word carries the low four bits of the flag byte.
  function automatic void predict_byte(input logic [7:0] b);
    logic [DATA_W-1:0] data;
    logic [7:0]        flags;
    chan_word_t        w;
    if (rx_pos == POS_IDLE) begin
      // a header only counts right after a footer value
      if (b == HDR_BYTE && rx_prev == FTR_BYTE) begin
        rx_pos = POS_FIRST;
        framed_bytes++;
      end
    end else if (rx_pos < POS_FOOTER) begin
      frame_bytes[rx_pos - POS_FIRST] = b;
      rx_pos = rx_pos + POS_FIRST;
      framed_bytes++;
    end else begin
      // footer slot; a bad footer drops the frame with no words
      rx_pos = POS_IDLE;
      framed_bytes++;
      if (b == FTR_BYTE) begin
        flags = frame_bytes[STORE_LEN - 1];
        for (int i = 0; i < DATA_BYTES; i++) data[8*i +: 8] = frame_bytes[i];
        for (int k = 0; k < NUM_CH; k++) begin
          w.idx = IDX_W'(k);
          w.value = data[CH_W*k +: CH_W];
          w.ch17 = flags[FLAG_CH17];
          w.ch18 = flags[FLAG_CH18];
          w.lost = flags[FLAG_LOST];
          w.fs = flags[FLAG_FS];
          w.last_ch = (w.idx == LAST_CH);
          expected_words.push_back(w);
        end
      end
    end
    // the previous byte follows every byte, the footer of a good frame too
    rx_prev = b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Output checker: each accepted word against the oldest expected word.
  always @(posedge clk) begin : word_check
    chan_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with none expected, channel_index", channel_index, -1);
      end else begin
        want = expected_words.pop_front();
        if (channel_index !== want.idx)
          report_mismatch("channel_index", channel_index, want.idx);
        if (channel_value !== want.value)
          report_mismatch("channel_value", channel_value, want.value);
        if (digital_ch17 !== want.ch17) report_mismatch("digital_ch17", digital_ch17, want.ch17);
        if (digital_ch18 !== want.ch18) report_mismatch("digital_ch18", digital_ch18, want.ch18);
        if (frame_lost !== want.lost) report_mismatch("frame_lost", frame_lost, want.lost);
        if (fail_safe !== want.fs) report_mismatch("fail_safe", fail_safe, want.fs);
        if (last !== want.last_ch) report_mismatch("last", last, want.last_ch);
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no word moving.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one byte word: optional gap, then valid held until accepted.
  // Valid stays high into the next word when no gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_byte(b);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Header, 22 data bytes, flag byte, footer. The caller sees to the byte before.
  task automatic send_frame(input logic [DATA_W-1:0] payload, input logic [7:0] flags,
                            input logic [7:0] footer);
    send_byte(HDR_BYTE);
    for (int i = 0; i < DATA_BYTES; i++) send_byte(payload[8*i +: 8]);
    send_byte(flags);
    send_byte(footer);
  endtask

  // Frame payloads: plain random, all ones, all zeros, or salted with the
  // header and footer values so they show up inside frame data.
  function automatic logic [DATA_W-1:0] random_payload();
    logic [DATA_W-1:0] p;
    int                style;
    int                r;
    style = $urandom_range(0, 9);
    for (int i = 0; i < DATA_BYTES; i++) begin
      r = $urandom_range(0, 3);
      if (style == 0) p[8*i +: 8] = 8'hFF;
      else if (style == 1) p[8*i +: 8] = 8'h00;
      else if (style < 4 && r == 0) p[8*i +: 8] = HDR_BYTE;
      else if (style < 4 && r == 1) p[8*i +: 8] = FTR_BYTE;
      else p[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  // Line is idle-low behind the decoder: get to a clean frame start.
  task automatic align_to_header();
    while (rx_pos != POS_IDLE) send_byte(8'($urandom_range(0, 255)));
    if (rx_prev != FTR_BYTE) send_byte(FTR_BYTE);
  endtask

  // Header bytes that do not follow a footer value are ignored.
  task automatic test_stray_header();
    send_byte(8'hA5);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(FTR_BYTE);
  endtask

  // Full-scale frame with every flag bit set, then a frame whose header
  // follows the good footer directly but ends on a bad footer; a header
  // right after that bad footer must be ignored.
  task automatic test_extreme_frames();
    send_frame('1, 8'hFF, FTR_BYTE);
    send_frame('0, 8'h00, 8'h80);
    send_byte(HDR_BYTE);
  endtask

  // Mostly well-formed frames with random content; the rest bad footers,
  // cut-off frames and line noise.
  task automatic test_random_stream(input int target);
    int r;
    int n;
    while (framed_bytes < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        align_to_header();
        send_frame(random_payload(), 8'($urandom_range(0, 255)), FTR_BYTE);
      end else if (r < 80) begin
        align_to_header();
        send_frame(random_payload(), 8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
      end else if (r < 87) begin
        // cut-off frame: later bytes land in its data slots
        align_to_header();
        send_byte(HDR_BYTE);
        n = $urandom_range(1, 20);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          r = $urandom_range(0, 2);
          send_byte(r == 0 ? HDR_BYTE : (r == 1 ? FTR_BYTE : 8'($urandom_range(0, 255))));
        end
      end
    end
  endtask

  // Sender holds off until every pending channel word is out, then goes on.
  task automatic test_pause_until_drained();
    align_to_header();
    send_frame(random_payload(), 8'($urandom_range(0, 255)), FTR_BYTE);
    idle_input();
    wait_drained();
    send_frame(random_payload(), 8'($urandom_range(0, 255)), FTR_BYTE);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_stray_header();
    test_extreme_frames();
    test_random_stream(MID_TARGET);
    test_pause_until_drained();
    test_random_stream(END_TARGET);

    idle_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
